// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked, reset-qualified implication checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds on the same edge.
`define DPEC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons holds on the following edge.
`define DPEC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dpec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual performance event counter package
// Field widths, command codes and configuration register indexes.
// ----------------------------------------------------------------------------
package dpec_pkg;

    localparam int unsigned CNT_W      = 32;
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned PRIV_W     = 2;
    localparam int unsigned EVT_W      = 5;
    localparam int unsigned MODE_W     = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 5;

    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [CMD_W-1:0]      t_cmd;
    typedef logic [PRIV_W-1:0]     t_priv;
    typedef logic [EVT_W-1:0]      t_evt;
    typedef logic [MODE_W-1:0]     t_mode;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // Command codes
    localparam t_cmd CMD_UPDATE = 2'd0;
    localparam t_cmd CMD_WR_CNT0 = 2'd1;
    localparam t_cmd CMD_WR_CNT1 = 2'd2;

    // Privilege codes
    localparam t_priv PRIV_KERNEL = 2'd0;
    localparam t_priv PRIV_SUPER  = 2'd1;
    localparam t_priv PRIV_USER   = 2'd2;

    // Mode enable bit positions
    localparam int unsigned MODE_EXL   = 0;
    localparam int unsigned MODE_KERN  = 1;
    localparam int unsigned MODE_SUPER = 2;
    localparam int unsigned MODE_USER  = 3;

    // Configuration register indexes
    localparam t_cfg_idx CFG_COUNT_EN = 3'd0;
    localparam t_cfg_idx CFG_EVT_SEL0 = 3'd1;
    localparam t_cfg_idx CFG_EVT_SEL1 = 3'd2;
    localparam t_cfg_idx CFG_MODE_EN0 = 3'd3;
    localparam t_cfg_idx CFG_MODE_EN1 = 3'd4;

    // Counting event codes: 1..3 and 12..15
    localparam t_evt EVT_LO_MIN = 5'd1;
    localparam t_evt EVT_LO_MAX = 5'd3;
    localparam t_evt EVT_HI_MIN = 5'd12;
    localparam t_evt EVT_HI_MAX = 5'd15;

    localparam int unsigned OVF_BIT = CNT_W - 1;

endpackage

// ===== src/dual_perf_event_counter_unit.sv =====
`timescale 1ns / 1ps
// A transaction is taken into the input register and moves into the result register once
// that register is empty or being drained; throughput is one per cycle while the consumer keeps up.
// Both counters and last stamps are written from the input register in the same
// cycle that the result register loads, so the next transaction sees them at once.
// Synchronous active-low reset clears counters, stamps, config and valid flags.
// The configuration channel is always ready and takes one write per cycle.
// ----------------------------------------------------------------------------
// Dual performance event counter unit
// Two 32-bit counters that advance by elapsed cycles in enabled processor
// states, with write commands that reload a counter and restart its stamp.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_perf_event_counter_unit
    import dpec_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,

    // configuration write channel
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  t_cfg_idx  i_cfg_index,
    input  t_cfg_data i_cfg_data,

    // input transaction channel
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_cmd      i_command,
    input  t_cnt      i_cycle_stamp,
    input  logic      i_error_level,
    input  logic      i_exception_level,
    input  t_priv     i_privilege,
    input  t_cnt      i_write_value,

    // result channel
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_cnt      o_counter0_value,
    output t_cnt      o_counter1_value,
    output logic      o_overflow0,
    output logic      o_overflow1
);

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic  r_count_en;
    t_evt  r_evt_sel0;
    t_evt  r_evt_sel1;
    t_mode r_mode_en0;
    t_mode r_mode_en1;

    logic  w_cfg_wr;

    // Always ready: each write is registered on the edge that accepts it, unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_en <= 1'b0;
            r_evt_sel0 <= '0;
            r_evt_sel1 <= '0;
            r_mode_en0 <= '0;
            r_mode_en1 <= '0;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                CFG_COUNT_EN: begin
                    r_count_en <= i_cfg_data[0];
                end
                CFG_EVT_SEL0: begin
                    r_evt_sel0 <= i_cfg_data[EVT_W-1:0];
                end
                CFG_EVT_SEL1: begin
                    r_evt_sel1 <= i_cfg_data[EVT_W-1:0];
                end
                CFG_MODE_EN0: begin
                    r_mode_en0 <= i_cfg_data[MODE_W-1:0];
                end
                CFG_MODE_EN1: begin
                    r_mode_en1 <= i_cfg_data[MODE_W-1:0];
                end
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Input register: one transaction deep, refilled in the cycle it drains
    // ------------------------------------------------------------------------
    logic  r_s1_valid;
    t_cmd  r_s1_cmd;
    t_cnt  r_s1_stamp;
    logic  r_s1_erl;
    logic  r_s1_exl;
    t_priv r_s1_priv;
    t_cnt  r_s1_wval;

    logic  r_out_valid;
    logic  w_take;      // input register moves into the result register
    logic  w_in_acc;

    assign w_take     = r_s1_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_s1_valid | w_take;
    assign w_in_acc   = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_cmd   <= i_command;
            r_s1_stamp <= i_cycle_stamp;
            r_s1_erl   <= i_error_level;
            r_s1_exl   <= i_exception_level;
            r_s1_priv  <= i_privilege;
            r_s1_wval  <= i_write_value;
        end
    end

    // ------------------------------------------------------------------------
    // Counter state
    // ------------------------------------------------------------------------
    t_cnt r_count0;
    t_cnt r_count1;
    t_cnt r_last0;
    t_cnt r_last1;

    t_cnt n_count0;
    t_cnt n_count1;
    t_cnt n_last0;
    t_cnt n_last1;

    // Event code qualifies when it falls in one of the two counting ranges.
    function automatic logic evt_counts(input t_evt code);
        return ((code >= EVT_LO_MIN) && (code <= EVT_LO_MAX)) ||
               ((code >= EVT_HI_MIN) && (code <= EVT_HI_MAX));
    endfunction

    // Exception-level enable, or the enable bit of the current privilege.
    function automatic logic mode_hit(input t_mode en, input logic exl, input t_priv priv);
        logic hit;
        hit = exl & en[MODE_EXL];
        unique case (priv)
            PRIV_KERNEL: hit = hit | en[MODE_KERN];
            PRIV_SUPER:  hit = hit | en[MODE_SUPER];
            PRIV_USER:   hit = hit | en[MODE_USER];
            default:     hit = hit;
        endcase
        return hit;
    endfunction

    // Elapsed cycles since the stamp, with zero elapsed counted as one.
    function automatic t_cnt advance(input t_cnt value, input t_cnt now, input t_cnt last);
        t_cnt diff;
        diff = now - last;
        return value + ((diff == '0) ? t_cnt'(1) : diff);
    endfunction

    logic w_gate;
    logic w_hit0;
    logic w_hit1;

    assign w_gate = ~r_s1_erl & r_count_en;
    assign w_hit0 = w_gate & evt_counts(r_evt_sel0) & mode_hit(r_mode_en0, r_s1_exl, r_s1_priv);
    assign w_hit1 = w_gate & evt_counts(r_evt_sel1) & mode_hit(r_mode_en1, r_s1_exl, r_s1_priv);

    always_comb begin
        n_count0 = r_count0;
        n_count1 = r_count1;
        n_last0  = r_last0;
        n_last1  = r_last1;
        unique case (r_s1_cmd)
            CMD_UPDATE: begin
                // advance qualifying counters, always move both stamps
                if (w_hit0) begin
                    n_count0 = advance(r_count0, r_s1_stamp, r_last0);
                end
                if (w_hit1) begin
                    n_count1 = advance(r_count1, r_s1_stamp, r_last1);
                end
                n_last0 = r_s1_stamp;
                n_last1 = r_s1_stamp;
            end
            CMD_WR_CNT0: begin
                n_count0 = r_s1_wval;
                n_last0  = r_s1_stamp;
            end
            CMD_WR_CNT1: begin
                n_count1 = r_s1_wval;
                n_last1  = r_s1_stamp;
            end
            default: begin
                // unused command: hold everything, report current counters
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count0 <= '0;
            r_count1 <= '0;
            r_last0  <= '0;
            r_last1  <= '0;
        end else if (w_take) begin
            r_count0 <= n_count0;
            r_count1 <= n_count1;
            r_last0  <= n_last0;
            r_last1  <= n_last1;
        end
    end

    // ------------------------------------------------------------------------
    // Result register: holds the snapshot until the consumer takes it
    // ------------------------------------------------------------------------
    t_cnt r_out_cnt0;
    t_cnt r_out_cnt1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_cnt0 <= n_count0;
            r_out_cnt1 <= n_count1;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_counter0_value = r_out_cnt0;
    assign o_counter1_value = r_out_cnt1;
    assign o_overflow0      = r_out_cnt0[OVF_BIT];
    assign o_overflow1      = r_out_cnt1[OVF_BIT];

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `DPEC_ASSERT_NXT(a_cnt_hold_idle, i_clk, i_rst_n, !w_take,
        $stable(r_count0) && $stable(r_count1) && $stable(r_last0) && $stable(r_last1),
        "counter state changed without a transaction")
    `DPEC_ASSERT_NXT(a_take_fills_out, i_clk, i_rst_n, w_take, r_out_valid,
        "result register not loaded after a transaction moved")
    `DPEC_ASSERT_NXT(a_erl_blocks, i_clk, i_rst_n,
        w_take && (r_s1_cmd == CMD_UPDATE) && r_s1_erl,
        $stable(r_count0) && $stable(r_count1),
        "counter advanced under error level")
    `DPEC_ASSERT_IMP(a_out_tracks_state, i_clk, i_rst_n,
        r_out_valid && !r_s1_valid,
        (r_out_cnt0 == r_count0) && (r_out_cnt1 == r_count1),
        "pending result differs from counter state")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual performance event counter testbench
// Streams processor samples (cycle stamp, state, command) into the counter
// unit under a series of register settings and checks every result against
// a cycle-free prediction of both counters and their overflow flags.
// ----------------------------------------------------------------------------
module tb_top;
    import dpec_pkg::*;

    // Codes that the package leaves unnamed but the fields can carry
    localparam t_cmd  CMD_UNUSED = 2'd3;
    localparam t_priv PRIV_NONE  = 2'd3;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 4;     // two-stage pipe plus margin
    localparam int HOLD_CYCLES  = 250;   // long receiver hold-off
    localparam int N_RAND_PHASE = 12;

    typedef struct packed {
        t_cmd  cmd;
        t_cnt  stamp;
        logic  erl;
        logic  exl;
        t_priv priv;
        t_cnt  wval;
    } t_sample;

    typedef struct packed {
        t_cnt c0;
        t_cnt c1;
        logic ovf0;
        logic ovf1;
    } t_counts;

    typedef struct packed {
        t_cfg_idx  idx;
        t_cfg_data data;
    } t_reg_write;

    // ------------------------------------------------------------------
    // Clock, reset and DUT signals
    // ------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic       cfg_valid = 1'b0;
    t_reg_write cfg_cur   = '0;
    logic       o_cfg_ready;

    logic    smp_valid = 1'b0;
    t_sample smp_cur   = '0;
    logic    o_in_ready;

    logic out_ready = 1'b0;
    logic o_out_valid;
    t_cnt o_counter0_value;
    t_cnt o_counter1_value;
    logic o_overflow0;
    logic o_overflow1;

    dual_perf_event_counter_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (cfg_cur.idx),
        .i_cfg_data        (cfg_cur.data),
        .i_in_valid        (smp_valid),
        .o_in_ready        (o_in_ready),
        .i_command         (smp_cur.cmd),
        .i_cycle_stamp     (smp_cur.stamp),
        .i_error_level     (smp_cur.erl),
        .i_exception_level (smp_cur.exl),
        .i_privilege       (smp_cur.priv),
        .i_write_value     (smp_cur.wval),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_counter0_value  (o_counter0_value),
        .o_counter1_value  (o_counter1_value),
        .o_overflow0       (o_overflow0),
        .o_overflow1       (o_overflow1)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hold reset from the start, then release it for the rest of the run
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Queues and bookkeeping
    // ------------------------------------------------------------------
    t_sample    sample_q[$];    // samples waiting to be offered
    t_reg_write cfg_q[$];       // register writes waiting to be offered
    t_counts    counts_due[$];  // predicted results, oldest first

    int   fail_count    = 0;
    int   n_samples     = 0;
    int   n_cfg_writes  = 0;
    int   n_phases      = 0;
    int   results_seen  = 0;
    int   holds_done    = 0;
    int   cycle_count   = 0;
    bit   tx_calm       = 1'b0;
    bit   rx_calm       = 1'b0;
    t_cnt stamp_now     = '0;

    // ------------------------------------------------------------------
    // Predictor: own copy of the registers and counter state
    // ------------------------------------------------------------------
    logic  pr_count_en = 1'b0;
    t_evt  pr_evt0     = '0;
    t_evt  pr_evt1     = '0;
    t_mode pr_mode0    = '0;
    t_mode pr_mode1    = '0;
    t_cnt  pr_cnt0     = '0;
    t_cnt  pr_cnt1     = '0;
    t_cnt  pr_last0    = '0;
    t_cnt  pr_last1    = '0;

    function automatic bit event_counts(input t_evt code);
        return (code >= EVT_LO_MIN && code <= EVT_LO_MAX) ||
               (code >= EVT_HI_MIN && code <= EVT_HI_MAX);
    endfunction

    // Exception-level enable or the enable of the current privilege.
    // An unknown privilege code enables nothing by itself.
    function automatic bit state_enabled(input t_mode en, input t_sample s);
        bit hit;
        hit = s.exl && en[MODE_EXL];
        case (s.priv)
            PRIV_KERNEL: hit |= en[MODE_KERN];
            PRIV_SUPER:  hit |= en[MODE_SUPER];
            PRIV_USER:   hit |= en[MODE_USER];
            default:     ;
        endcase
        return hit;
    endfunction

    // Elapsed cycles, wrapping modulo 2^32; zero elapsed counts as one
    function automatic t_cnt elapsed(input t_cnt now, input t_cnt last);
        t_cnt d;
        d = now - last;
        return (d == '0) ? t_cnt'(1) : d;
    endfunction

    function automatic t_counts step_counters(input t_sample s);
        t_counts r;
        case (s.cmd)
            CMD_UPDATE: begin
                if (!s.erl && pr_count_en) begin
                    if (state_enabled(pr_mode0, s) && event_counts(pr_evt0))
                        pr_cnt0 = pr_cnt0 + elapsed(s.stamp, pr_last0);
                    if (state_enabled(pr_mode1, s) && event_counts(pr_evt1))
                        pr_cnt1 = pr_cnt1 + elapsed(s.stamp, pr_last1);
                end
                pr_last0 = s.stamp;
                pr_last1 = s.stamp;
            end
            CMD_WR_CNT0: begin
                pr_cnt0  = s.wval;
                pr_last0 = s.stamp;
            end
            CMD_WR_CNT1: begin
                pr_cnt1  = s.wval;
                pr_last1 = s.stamp;
            end
            default: ;  // unused command: leave everything as it is
        endcase
        r.c0   = pr_cnt0;
        r.c1   = pr_cnt1;
        r.ovf0 = pr_cnt0[OVF_BIT];
        r.ovf1 = pr_cnt1[OVF_BIT];
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Sample driver: pop the next sample once the current one is taken
    // ------------------------------------------------------------------
    int tx_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_valid <= 1'b0;
            tx_gap    <= 0;
        end else begin
            // Predict on acceptance so the state order matches the DUT
            if (smp_valid && o_in_ready) begin
                counts_due.push_back(step_counters(smp_cur));
                n_samples++;
            end
            if (!smp_valid || o_in_ready) begin
                if (tx_gap > 0) begin
                    smp_valid <= 1'b0;
                    tx_gap    <= tx_gap - 1;
                end else if (sample_q.size() > 0) begin
                    smp_cur   <= sample_q.pop_front();
                    smp_valid <= 1'b1;
                    tx_gap    <= tx_calm ? 0 : idle_len();
                end else begin
                    smp_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Register write driver; the predictor takes each write on acceptance
    // ------------------------------------------------------------------
    int cfg_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_valid <= 1'b0;
            cfg_gap   <= 0;
        end else begin
            if (cfg_valid && o_cfg_ready) begin
                n_cfg_writes++;
                case (cfg_cur.idx)
                    CFG_COUNT_EN: pr_count_en = cfg_cur.data[0];
                    CFG_EVT_SEL0: pr_evt0     = cfg_cur.data[EVT_W-1:0];
                    CFG_EVT_SEL1: pr_evt1     = cfg_cur.data[EVT_W-1:0];
                    CFG_MODE_EN0: pr_mode0    = cfg_cur.data[MODE_W-1:0];
                    CFG_MODE_EN1: pr_mode1    = cfg_cur.data[MODE_W-1:0];
                    default:      ;  // unmapped index: dropped by the block
                endcase
            end
            if (!cfg_valid || o_cfg_ready) begin
                if (cfg_gap > 0) begin
                    cfg_valid <= 1'b0;
                    cfg_gap   <= cfg_gap - 1;
                end else if (cfg_q.size() > 0) begin
                    cfg_cur   <= cfg_q.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_gap   <= $urandom_range(0, 2);
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result ready: random stalls, plus two long hold-offs while samples
    // are still queued so the pipe fills and back-pressures the input
    // ------------------------------------------------------------------
    int rx_stall  = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            rx_stall  <= 0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (sample_q.size() > 20 &&
                     ((holds_done == 0 && results_seen >= 150) ||
                      (holds_done == 1 && results_seen >= 600))) begin
            out_ready  <= 1'b0;
            hold_left  <= HOLD_CYCLES - 1;
            holds_done <= holds_done + 1;
        end else if (rx_stall > 0) begin
            out_ready <= 1'b0;
            rx_stall  <= rx_stall - 1;
        end else if (rx_calm) begin
            out_ready <= 1'b1;
        end else begin
            int n;
            n = idle_len();
            out_ready <= (n == 0);
            rx_stall  <= (n > 0) ? n - 1 : 0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each taken result with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            results_seen <= results_seen + 1;
            if (counts_due.size() == 0) begin
                $error("result transaction with no prediction pending");
                fail_count++;
            end else begin
                t_counts want;
                want = counts_due.pop_front();
                if (o_counter0_value !== want.c0) begin
                    $error("counter0_value: expected %h, got %h", want.c0, o_counter0_value);
                    fail_count++;
                end
                if (o_counter1_value !== want.c1) begin
                    $error("counter1_value: expected %h, got %h", want.c1, o_counter1_value);
                    fail_count++;
                end
                if (o_overflow0 !== want.ovf0) begin
                    $error("overflow0: expected %b, got %b", want.ovf0, o_overflow0);
                    fail_count++;
                end
                if (o_overflow1 !== want.ovf1) begin
                    $error("overflow1: expected %b, got %b", want.ovf1, o_overflow1);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_sample(input t_cmd cmd, input t_cnt stamp, input logic erl,
                              input logic exl, input t_priv priv, input t_cnt wval);
        t_sample s;
        s.cmd   = cmd;
        s.stamp = stamp;
        s.erl   = erl;
        s.exl   = exl;
        s.priv  = priv;
        s.wval  = wval;
        sample_q.push_back(s);
    endtask

    // Hold until every queued transaction is through and every result is in
    task automatic wait_drained();
        while (sample_q.size() != 0 || smp_valid || counts_due.size() != 0 ||
               cfg_q.size() != 0 || cfg_valid)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write all five registers; unused data bits get random values so the
    // masking is exercised. Optionally slip in a write to an unmapped index.
    task automatic program_counters(input bit en, input t_evt e0, input t_evt e1,
                                    input t_mode m0, input t_mode m1, input bit stray);
        t_reg_write w;
        wait_drained();
        if (stray) begin
            w.idx  = t_cfg_idx'($urandom_range(int'(CFG_MODE_EN1) + 1, (1 << CFG_IDX_W) - 1));
            w.data = t_cfg_data'($urandom);
            cfg_q.push_back(w);
        end
        w.idx  = CFG_COUNT_EN;
        w.data = t_cfg_data'($urandom);
        w.data[0] = en;
        cfg_q.push_back(w);
        w.idx  = CFG_EVT_SEL0;
        w.data = e0;
        cfg_q.push_back(w);
        w.idx  = CFG_EVT_SEL1;
        w.data = e1;
        cfg_q.push_back(w);
        w.idx  = CFG_MODE_EN0;
        w.data = t_cfg_data'($urandom);
        w.data[MODE_W-1:0] = m0;
        cfg_q.push_back(w);
        w.idx  = CFG_MODE_EN1;
        w.data = t_cfg_data'($urandom);
        w.data[MODE_W-1:0] = m1;
        cfg_q.push_back(w);
        wait_drained();
        n_phases++;
    endtask

    // Mostly a counting code, sometimes any code at all
    function automatic t_evt pick_event();
        int r;
        if ($urandom_range(0, 9) < 3) return t_evt'($urandom);
        r = $urandom_range(0, 6);
        return (r < 3) ? t_evt'(EVT_LO_MIN + r) : t_evt'(EVT_HI_MIN + (r - 3));
    endfunction

    function automatic t_cnt pick_value();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2:       return t_cnt'(32'h7FFF_FFFF);
            3:       return t_cnt'(32'h8000_0000);
            default: return t_cnt'($urandom);
        endcase
    endfunction

    // Well-formed stream: stamps advance by small steps (zero included),
    // with occasional long jumps and arbitrary stamps as noise.
    task automatic add_random_samples(input int n);
        int   r;
        t_cmd cmd;
        t_priv priv;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 10)      ;
            else if (r < 80) stamp_now += $urandom_range(1, 16);
            else if (r < 93) stamp_now += $urandom_range(17, 5000);
            else             stamp_now = $urandom;
            r = $urandom_range(0, 99);
            if (r < 80)      cmd = CMD_UPDATE;
            else if (r < 88) cmd = CMD_WR_CNT0;
            else if (r < 96) cmd = CMD_WR_CNT1;
            else             cmd = CMD_UNUSED;
            r = $urandom_range(0, 99);
            if (r < 95) priv = t_priv'($urandom_range(int'(PRIV_KERNEL), int'(PRIV_USER)));
            else        priv = PRIV_NONE;
            add_sample(cmd, stamp_now, ($urandom_range(0, 9) == 0),
                       ($urandom_range(0, 9) < 3), priv, pick_value());
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial begin
        @(posedge i_clk iff i_rst_n);
        @(negedge i_clk);

        // Reset settings: counting disabled, stamps still move
        add_sample(CMD_UPDATE, 32'd100, 1'b0, 1'b0, PRIV_KERNEL, '0);
        add_sample(CMD_UPDATE, 32'd250, 1'b0, 1'b1, PRIV_USER, '1);
        n_phases++;

        // Everything counts on both counters
        program_counters(1'b1, EVT_LO_MIN, EVT_HI_MAX, '1, '1, 1'b1);
        add_sample(CMD_UPDATE, 32'd260, 1'b0, 1'b0, PRIV_KERNEL, '0);
        add_sample(CMD_UPDATE, 32'd260, 1'b0, 1'b0, PRIV_KERNEL, '0);  // zero elapsed
        add_sample(CMD_UPDATE, 32'd300, 1'b1, 1'b0, PRIV_KERNEL, '0);  // error level
        add_sample(CMD_UPDATE, 32'd305, 1'b0, 1'b0, PRIV_SUPER, '0);
        add_sample(CMD_WR_CNT0, 32'd310, 1'b0, 1'b0, PRIV_KERNEL, '1);
        add_sample(CMD_UPDATE, 32'd312, 1'b0, 1'b0, PRIV_USER, '0);    // counter 0 wraps
        add_sample(CMD_WR_CNT1, 32'd320, 1'b0, 1'b0, PRIV_KERNEL, t_cnt'(32'h7FFF_FFFF));
        add_sample(CMD_UPDATE, 32'd321, 1'b0, 1'b0, PRIV_KERNEL, '0);  // into bit 31
        add_sample(CMD_UNUSED, 32'd999, 1'b1, 1'b1, PRIV_NONE, '1);    // ignored command
        add_sample(CMD_UPDATE, 32'd1000, 1'b0, 1'b0, PRIV_NONE, '0);
        add_sample(CMD_UPDATE, 32'd1010, 1'b0, 1'b1, PRIV_NONE, '0);
        add_sample(CMD_UPDATE, 32'hFFFF_FFF0, 1'b0, 1'b0, PRIV_SUPER, '0);
        add_sample(CMD_UPDATE, 32'h0000_0010, 1'b0, 1'b0, PRIV_USER, '0); // stamp wraps
        add_sample(CMD_WR_CNT0, 32'h0000_0020, 1'b0, 1'b0, PRIV_KERNEL, '0);
        add_sample(CMD_WR_CNT1, 32'h0000_0030, 1'b0, 1'b0, PRIV_KERNEL,
                   t_cnt'(32'h8000_0000));
        add_sample(CMD_UPDATE, '1, 1'b0, 1'b0, PRIV_KERNEL, '1);

        // Non-counting event codes at both extremes
        program_counters(1'b1, '0, '1, '1, '1, 1'b0);
        add_sample(CMD_UPDATE, 32'd40, 1'b0, 1'b0, PRIV_KERNEL, '0);
        add_sample(CMD_UPDATE, 32'd80, 1'b0, 1'b1, PRIV_USER, '0);

        // One enable bit per counter: exception level on 0, supervisor on 1
        program_counters(1'b1, EVT_HI_MIN, EVT_LO_MAX, t_mode'(1 << MODE_EXL),
                         t_mode'(1 << MODE_SUPER), 1'b0);
        add_sample(CMD_UPDATE, 32'd90, 1'b0, 1'b0, PRIV_KERNEL, '0);
        add_sample(CMD_UPDATE, 32'd95, 1'b0, 1'b0, PRIV_SUPER, '0);
        add_sample(CMD_UPDATE, 32'd97, 1'b0, 1'b1, PRIV_KERNEL, '0);
        add_sample(CMD_UPDATE, 32'd103, 1'b0, 1'b1, PRIV_USER, '0);
        add_sample(CMD_UPDATE, 32'd110, 1'b1, 1'b1, PRIV_SUPER, '0);
        stamp_now = 32'd110;

        // Random phases; the first few pin the register extremes
        for (int p = 0; p < N_RAND_PHASE; p++) begin
            case (p)
                0: program_counters(1'b1, EVT_LO_MIN, EVT_HI_MAX, '1, '1, 1'b0);
                1: program_counters(1'b1, '0, '1, '1, '0, 1'b1);
                2: program_counters(1'b0, EVT_LO_MAX, EVT_HI_MIN, '1, '1, 1'b0);
                3: program_counters(1'b1, EVT_LO_MAX, EVT_HI_MIN, '0, '1, 1'b0);
                default:
                    program_counters(($urandom_range(0, 7) != 0), pick_event(),
                                     pick_event(), t_mode'($urandom), t_mode'($urandom),
                                     ($urandom_range(0, 2) == 0));
            endcase
            // Some phases run without any idling on one or both sides
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) stamp_now = t_cnt'(32'hFFFF_FF00);
            add_random_samples($urandom_range(50, 80));
        end

        wait_drained();
        if (counts_due.size() != 0) begin
            $error("%0d predicted results never arrived", counts_due.size());
            fail_count++;
        end

        $display("Run covered %0d sample transactions and %0d results over %0d settings",
                 n_samples, results_seen, n_phases);
        $display("with %0d register writes, %0d long receiver hold-offs, %0d mismatches",
                 n_cfg_writes, holds_done, fail_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/dpec_pkg.sv
src/dual_perf_event_counter_unit.sv
dv/tb_top.sv
